@@ rtl/sv39_page_table_walker_assert.svh @@
// Assertion macros for the Sv39 page table walker.
`ifndef SV39_PAGE_TABLE_WALKER_ASSERT_SVH
`define SV39_PAGE_TABLE_WALKER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SV39PTW_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define SV39PTW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/sv39ptw_pkg.sv @@
// Types and constants shared by the Sv39 page table walker.
package sv39ptw_pkg;

  localparam int PPN_W            = 44;
  localparam int PTE_W            = 54;
  localparam int VA_W             = 39;
  localparam int PA_W             = 56;
  localparam int IDX_W            = 9;
  localparam int OFFSET_W         = 12;
  localparam int ENTRY_IDX_W      = 12;
  localparam int ENTRIES_PER_PAGE = 512;
  localparam int WRITE_WORDS      = 4096;  // words reachable by entry_index
  localparam int PTE_V_BIT        = 0;
  localparam int PTE_U_BIT        = 4;
  localparam int PTE_PPN_LSB      = 10;
  localparam int CFG_IDX_W        = 2;

  localparam logic [1:0] TOP_LEVEL = 2'd2;

  typedef enum logic [0:0] {
    ACT_WRITE     = 1'b0,
    ACT_TRANSLATE = 1'b1
  } action_t;

  typedef enum logic [2:0] {
    STS_OK       = 3'd0,
    STS_OVER     = 3'd1,
    STS_INVALID  = 3'd2,
    STS_NOT_USER = 3'd3,
    STS_OUTSIDE  = 3'd4,
    STS_WRITTEN  = 3'd5
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROOT_PPN = 2'd0,
    CFG_BASE_PPN = 2'd1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_HOLD
  } state_t;

  typedef struct packed {
    action_t                action;
    logic [ENTRY_IDX_W-1:0] entry_index;
    logic [PTE_W-1:0]       entry_value;
    logic [VA_W-1:0]        virtual_addr;
  } req_t;

  typedef struct packed {
    logic [PA_W-1:0] phys_addr;
    status_t         status;
    logic [1:0]      fault_level;
  } rsp_t;

endpackage

@@ rtl/sv39_page_table_walker.sv @@
// Sv39 page table walker top level: table store, walk sequencer, result register.
//
// Sv39 page table walker. Items arrive on the req channel: a write puts one 54-bit
// entry into the table store, a translate walks the three-level table from page
// root_table_ppn and returns the page base address (PPN << 12) or a fault status.
// Each transfer produces exactly one rsp transfer. A write or an over-limit
// address is answered without a walk; a full translation makes three dependent
// reads of the single store port, the level 2 read being issued in the accept
// cycle and the level 0 data being checked straight into the result register;
// a walk that faults early skips the lower levels. No req is taken during a walk.
// The result register lets the next item in while a result is waiting; if a
// second result is ready before the first is taken it is parked and the block
// stalls req until rsp drains. After reset the whole store is cleared one word
// a cycle, and req_ready stays low meanwhile; cfg writes are taken at any time.
// Only the first 4096 words are writable, so the store is sized to at most that
// and words above it always read as zero (invalid).
module sv39_page_table_walker #(
  parameter int TABLE_PAGES = 8
) (
  input  logic                                    clk,
  input  logic                                    rst,
  // configuration writes
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [sv39ptw_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sv39ptw_pkg::PPN_W-1:0]           cfg_data,
  // request channel
  input  logic                                    req_valid,
  output logic                                    req_ready,
  input  sv39ptw_pkg::req_t                       req,
  // response channel
  output logic                                    rsp_valid,
  input  logic                                    rsp_ready,
  output sv39ptw_pkg::rsp_t                       rsp
);

  // Store size: only entry_index can fill it, so nothing above 4096 words exists.
  localparam int STORE_WORDS = TABLE_PAGES * sv39ptw_pkg::ENTRIES_PER_PAGE;
  localparam int MEM_WORDS   = (STORE_WORDS < sv39ptw_pkg::WRITE_WORDS) ?
                               STORE_WORDS : sv39ptw_pkg::WRITE_WORDS;
  localparam int MEM_PAGES   = MEM_WORDS / sv39ptw_pkg::ENTRIES_PER_PAGE;
  localparam int MEM_AW      = $clog2(MEM_WORDS);
  localparam int PPN_W       = sv39ptw_pkg::PPN_W;
  localparam int PTE_W       = sv39ptw_pkg::PTE_W;
  localparam int IDX_W       = sv39ptw_pkg::IDX_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [PPN_W-1:0] root_table_ppn;
  logic [PPN_W-1:0] store_base_ppn;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      root_table_ppn <= '0;
      store_base_ppn <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        sv39ptw_pkg::CFG_ROOT_PPN: root_table_ppn <= cfg_data;
        sv39ptw_pkg::CFG_BASE_PPN: store_base_ppn <= cfg_data;
        default: ;  // unknown index: dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Control and datapath registers
  // ---------------------------------------------------------------------------
  sv39ptw_pkg::state_t state, state_next;
  logic [MEM_AW-1:0]   clr_addr;
  logic [1:0]          level, level_next;   // level of the read in flight
  logic [2*IDX_W-1:0]  va_lo;               // va[29:12], indexes for levels 1 and 0
  logic                rd_zero;             // read fell above the store: entry is zero
  sv39ptw_pkg::rsp_t   pend;                // parked result while rsp is occupied

  // Table store, one port.
  logic [PTE_W-1:0]  mem [MEM_WORDS];
  logic [PTE_W-1:0]  rdata;
  logic              mem_we, mem_re;
  logic [MEM_AW-1:0] mem_addr;
  logic [PTE_W-1:0]  mem_wdata;

  // Shared lookup: page -> store-relative address and range checks.
  logic [PPN_W-1:0]        lk_page;
  logic [IDX_W-1:0]        lk_idx;
  logic [PPN_W:0]          lk_diff;
  logic                    lk_outside, lk_in_mem;
  logic [PPN_W+IDX_W-1:0]  lk_word;

  logic              req_xfer, out_free, clr_last;
  logic              walk_go, fin_valid;
  sv39ptw_pkg::rsp_t fin;
  logic [PTE_W-1:0]  pte;

  assign req_xfer = req_valid && req_ready;
  assign out_free = !rsp_valid || rsp_ready;
  assign clr_last = (clr_addr == MEM_AW'(MEM_WORDS - 1));

  // Page below base borrows; page at or beyond base+TABLE_PAGES is outside.
  assign lk_diff    = {1'b0, lk_page} - {1'b0, store_base_ppn};
  assign lk_outside = lk_diff[PPN_W] || (lk_diff[PPN_W-1:0] >= PPN_W'(TABLE_PAGES));
  assign lk_in_mem  = lk_diff[PPN_W-1:0] < PPN_W'(MEM_PAGES);
  assign lk_word    = {lk_diff[PPN_W-1:0], lk_idx};

  assign pte = rd_zero ? '0 : rdata;

  // ---------------------------------------------------------------------------
  // Output and datapath control
  // ---------------------------------------------------------------------------
  always_comb begin
    req_ready  = 1'b0;
    lk_page    = root_table_ppn;
    lk_idx     = req.virtual_addr[38:30];
    level_next = sv39ptw_pkg::TOP_LEVEL;
    walk_go    = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_addr   = lk_word[MEM_AW-1:0];
    mem_wdata  = '0;
    fin_valid  = 1'b0;
    fin        = '0;
    case (state)
      sv39ptw_pkg::S_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_addr;
      end
      sv39ptw_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          if (req.action == sv39ptw_pkg::ACT_WRITE) begin
            mem_we     = ({1'b0, req.entry_index} < 13'(MEM_WORDS));
            mem_addr   = req.entry_index[MEM_AW-1:0];
            mem_wdata  = req.entry_value;
            fin_valid  = 1'b1;
            fin.status = sv39ptw_pkg::STS_WRITTEN;
          end else if (req.virtual_addr[38]) begin
            fin_valid  = 1'b1;
            fin.status = sv39ptw_pkg::STS_OVER;
          end else if (lk_outside) begin
            fin_valid       = 1'b1;
            fin.status      = sv39ptw_pkg::STS_OUTSIDE;
            fin.fault_level = sv39ptw_pkg::TOP_LEVEL;
          end else begin
            walk_go = 1'b1;
            mem_re  = lk_in_mem;
          end
        end
      end
      sv39ptw_pkg::S_READ: begin
        // Data of the current level is in rdata; follow it to the next level.
        lk_page    = pte[sv39ptw_pkg::PTE_PPN_LSB +: PPN_W];
        lk_idx     = (level == sv39ptw_pkg::TOP_LEVEL) ? va_lo[2*IDX_W-1:IDX_W]
                                                       : va_lo[IDX_W-1:0];
        level_next = level - 2'd1;
        if (!pte[sv39ptw_pkg::PTE_V_BIT]) begin
          fin_valid       = 1'b1;
          fin.status      = sv39ptw_pkg::STS_INVALID;
          fin.fault_level = level;
        end else if (level == 2'd0) begin
          fin_valid = 1'b1;
          if (pte[sv39ptw_pkg::PTE_U_BIT]) begin
            fin.status    = sv39ptw_pkg::STS_OK;
            fin.phys_addr = {lk_page, {sv39ptw_pkg::OFFSET_W{1'b0}}};
          end else begin
            fin.status = sv39ptw_pkg::STS_NOT_USER;
          end
        end else if (lk_outside) begin
          fin_valid       = 1'b1;
          fin.status      = sv39ptw_pkg::STS_OUTSIDE;
          fin.fault_level = level_next;
        end else begin
          walk_go = 1'b1;
          mem_re  = lk_in_mem;
        end
      end
      sv39ptw_pkg::S_HOLD: begin
        fin_valid = 1'b1;
        fin       = pend;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      sv39ptw_pkg::S_CLEAR: begin
        if (clr_last) state_next = sv39ptw_pkg::S_IDLE;
      end
      sv39ptw_pkg::S_IDLE: begin
        if (walk_go)                    state_next = sv39ptw_pkg::S_READ;
        else if (fin_valid && !out_free) state_next = sv39ptw_pkg::S_HOLD;
      end
      sv39ptw_pkg::S_READ: begin
        if (!walk_go) state_next = out_free ? sv39ptw_pkg::S_IDLE : sv39ptw_pkg::S_HOLD;
      end
      sv39ptw_pkg::S_HOLD: begin
        if (out_free) state_next = sv39ptw_pkg::S_IDLE;
      end
      default: state_next = sv39ptw_pkg::S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sv39ptw_pkg::S_CLEAR;
      clr_addr  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == sv39ptw_pkg::S_CLEAR) clr_addr <= clr_addr + MEM_AW'(1);
      if (fin_valid && out_free) rsp_valid <= 1'b1;
      else if (rsp_ready)        rsp_valid <= 1'b0;
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk) begin
    if (walk_go) begin
      level   <= level_next;
      rd_zero <= !lk_in_mem;
    end
    if (req_xfer) va_lo <= req.virtual_addr[29:12];
    if (fin_valid && out_free) rsp <= fin;
    if (fin_valid && !out_free && state != sv39ptw_pkg::S_HOLD) pend <= fin;
  end

  // Table store: one access per cycle, registered read data.
  always_ff @(posedge clk) begin
    if (mem_we)      mem[mem_addr] <= mem_wdata;
    else if (mem_re) rdata <= mem[mem_addr];
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
`include "sv39_page_table_walker_assert.svh"

  // An accepted item is either still walking, parked, or already in rsp.
  `SV39PTW_ASSERT_NEXT(a_item_tracked, clk, rst, req_xfer, (state != sv39ptw_pkg::S_IDLE) || rsp_valid, "accepted item lost")
  // A parked result only exists behind an occupied result register.
  `SV39PTW_ASSERT_NOW(a_hold_occupied, clk, rst, state == sv39ptw_pkg::S_HOLD, rsp_valid, "parked result with empty rsp")
  // Fault level is only reported for invalid or outside-store faults.
  `SV39PTW_ASSERT_NOW(a_level_zero, clk, rst, rsp_valid && (rsp.status != sv39ptw_pkg::STS_INVALID) && (rsp.status != sv39ptw_pkg::STS_OUTSIDE), rsp.fault_level == 2'd0, "stray fault level")
  // Nothing is accepted during the clearing pass.
  `SV39PTW_ASSERT_NEXT(a_clear_blocks, clk, rst, (state == sv39ptw_pkg::S_CLEAR) && !clr_last, !req_xfer || (state != sv39ptw_pkg::S_CLEAR), "request taken while clearing")

endmodule
